// File: rtl/sme_pkg.sv
package sme_pkg;

    localparam int FIELD_W = 4;
    localparam int CMD_W   = 2;
    localparam int AC_W    = 5;

    localparam logic [AC_W-1:0]  AC_RESET      = 5'd16;

    localparam logic [CMD_W-1:0] CMD_LOAD_PROP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_REV  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN       = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_POP,
        ST_CHECK,
        ST_PREF,
        ST_RANK1,
        ST_RANK2,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic take;
        logic load_prop;
        logic load_rev;
        logic init;
        logic pop;
        logic issue_pref;
        logic hold_w;
        logic cap_rank;
        logic match_free;
        logic swap;
        logic emit;
    } t_ctrl;

    typedef struct packed {
        logic queue_empty;
        logic exhausted;
        logic w_in_range;
        logic w_free;
        logic rank_better;
        logic out_free;
        logic out_last;
    } t_status;

endpackage

// File: rtl/sme_in_if.sv
interface sme_in_if;
    import sme_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [FIELD_W-1:0] person;
    logic [FIELD_W-1:0] rank;
    logic [FIELD_W-1:0] choice;

    modport source (output valid, output command, output person, output rank,
                    output choice, input ready);
    modport sink   (input valid, input command, input person, input rank,
                    input choice, output ready);
endinterface

// File: rtl/sme_out_if.sv
interface sme_out_if;
    import sme_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] proposer;
    logic [FIELD_W-1:0] partner;
    logic               last;

    modport source (output valid, output proposer, output partner, output last,
                    input ready);
    modport sink   (input valid, input proposer, input partner, input last,
                    output ready);
endinterface

// File: rtl/sme_cfg_if.sv
interface sme_cfg_if;
    import sme_pkg::*;

    logic            valid;
    logic            ready;
    logic [AC_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sme_ctrl.sv
module sme_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic [sme_pkg::CMD_W-1:0]     i_req_command,
    input  sme_pkg::t_status              i_sts,
    output sme_pkg::t_ctrl                o_ctl
);
    import sme_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                o_ctl.take = 1'b1;
                if (i_req_valid) begin
                    case (i_req_command)
                        CMD_LOAD_PROP: o_ctl.load_prop = 1'b1;
                        CMD_LOAD_REV:  o_ctl.load_rev  = 1'b1;
                        CMD_RUN:       n_state         = ST_INIT;
                        default:       n_state         = ST_IDLE;
                    endcase
                end
            end
            ST_INIT: begin
                o_ctl.init = 1'b1;
                n_state    = ST_POP;
            end
            ST_POP: begin
                if (i_sts.queue_empty) begin
                    n_state = ST_OUT;
                end else begin
                    o_ctl.pop = 1'b1;
                    n_state   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.exhausted) begin
                    n_state = ST_POP;
                end else begin
                    o_ctl.issue_pref = 1'b1;
                    n_state          = ST_PREF;
                end
            end
            ST_PREF: begin
                if (!i_sts.w_in_range) begin
                    n_state = ST_CHECK;
                end else if (i_sts.w_free) begin
                    o_ctl.match_free = 1'b1;
                    n_state          = ST_POP;
                end else begin
                    o_ctl.hold_w = 1'b1;
                    n_state      = ST_RANK1;
                end
            end
            ST_RANK1: begin
                o_ctl.cap_rank = 1'b1;
                n_state        = ST_RANK2;
            end
            ST_RANK2: begin
                if (i_sts.rank_better) begin
                    o_ctl.swap = 1'b1;
                    n_state    = ST_POP;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    if (i_sts.out_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: rtl/sme_datapath.sv
module sme_datapath #(
    parameter int MAX_PEOPLE = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sme_pkg::t_ctrl                i_ctl,
    output sme_pkg::t_status              o_sts,
    input  logic [sme_pkg::FIELD_W-1:0]   i_person,
    input  logic [sme_pkg::FIELD_W-1:0]   i_rank,
    input  logic [sme_pkg::FIELD_W-1:0]   i_choice,
    input  logic                          i_cfg_valid,
    input  logic [sme_pkg::AC_W-1:0]      i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [sme_pkg::FIELD_W-1:0]   o_proposer,
    output logic [sme_pkg::FIELD_W-1:0]   o_partner,
    output logic                          o_last
);
    import sme_pkg::*;

    localparam int IW    = $clog2(MAX_PEOPLE);
    localparam int CW    = $clog2(MAX_PEOPLE + 1);
    localparam int DEPTH = MAX_PEOPLE * MAX_PEOPLE;
    localparam int AW    = $clog2(DEPTH);

    // preference and rank-of tables
    logic [FIELD_W-1:0] r_prefs [DEPTH];
    logic [FIELD_W-1:0] r_ranks [DEPTH];
    logic [FIELD_W-1:0] r_pref_rd;
    logic [FIELD_W-1:0] r_rank_rd;

    logic               r_rmatch   [MAX_PEOPLE];
    logic               r_pmatch   [MAX_PEOPLE];
    logic [IW-1:0]      r_rpartner [MAX_PEOPLE];
    logic [IW-1:0]      r_ppartner [MAX_PEOPLE];
    logic [CW-1:0]      r_nc       [MAX_PEOPLE];
    logic [IW-1:0]      r_queue    [MAX_PEOPLE];

    logic [IW-1:0]      r_head;
    logic [IW-1:0]      r_tail;
    logic [CW-1:0]      r_count;
    logic [IW-1:0]      r_m;
    logic [IW-1:0]      r_w;
    logic [IW-1:0]      r_other;
    logic [FIELD_W-1:0] r_rank_m;
    logic [IW-1:0]      r_oidx;
    logic [AC_W-1:0]    r_ac;

    logic               r_out_valid;
    logic [FIELD_W-1:0] r_proposer;
    logic [FIELD_W-1:0] r_partner;
    logic               r_last;

    logic [CW-1:0]      people;
    logic [IW-1:0]      w_idx;
    logic [AW-1:0]      pref_raddr;
    logic [AW-1:0]      rank_raddr;
    logic [AW-1:0]      prop_waddr;
    logic [AW-1:0]      rev_waddr;
    logic               prop_we;
    logic               rev_we;

    always_comb begin
        if (r_ac == '0) begin
            people = CW'(1);
        end else if (int'(r_ac) > MAX_PEOPLE) begin
            people = CW'(MAX_PEOPLE);
        end else begin
            people = CW'(r_ac);
        end
    end

    assign w_idx = IW'(r_pref_rd);

    always_comb begin
        pref_raddr = AW'(r_m) * AW'(MAX_PEOPLE) + AW'(IW'(r_nc[r_m]));
        if (i_ctl.hold_w) begin
            rank_raddr = AW'(w_idx) * AW'(MAX_PEOPLE) + AW'(r_m);
        end else begin
            rank_raddr = AW'(r_w) * AW'(MAX_PEOPLE) + AW'(r_other);
        end
        prop_waddr = AW'(IW'(i_person)) * AW'(MAX_PEOPLE) + AW'(IW'(i_rank));
        rev_waddr  = AW'(IW'(i_person)) * AW'(MAX_PEOPLE) + AW'(IW'(i_choice));
        prop_we    = i_ctl.load_prop && (int'(i_person) < MAX_PEOPLE)
                     && (int'(i_rank) < MAX_PEOPLE);
        rev_we     = i_ctl.load_rev && (int'(i_person) < MAX_PEOPLE)
                     && (int'(i_rank) < MAX_PEOPLE) && (int'(i_choice) < MAX_PEOPLE);
    end

    always_ff @(posedge i_clk) begin
        if (prop_we) begin
            r_prefs[prop_waddr] <= i_choice;
        end
        r_pref_rd <= r_prefs[pref_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rev_we) begin
            r_ranks[rev_waddr] <= i_rank;
        end
        r_rank_rd <= r_ranks[rank_raddr];
    end

    // matched flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PEOPLE; i++) begin
                r_rmatch[i] <= 1'b0;
                r_pmatch[i] <= 1'b0;
            end
        end else if (i_ctl.init) begin
            for (int i = 0; i < MAX_PEOPLE; i++) begin
                r_rmatch[i] <= 1'b0;
                r_pmatch[i] <= 1'b0;
            end
        end else if (i_ctl.match_free) begin
            r_rmatch[w_idx] <= 1'b1;
            r_pmatch[r_m]   <= 1'b1;
        end else if (i_ctl.swap) begin
            r_pmatch[r_m]     <= 1'b1;
            r_pmatch[r_other] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            for (int i = 0; i < MAX_PEOPLE; i++) begin
                r_nc[i]    <= '0;
                r_queue[i] <= IW'(i);
            end
        end
        if (i_ctl.pop) begin
            r_m <= r_queue[r_head];
        end
        if (i_ctl.issue_pref) begin
            r_nc[r_m] <= r_nc[r_m] + 1'b1;
        end
        if (i_ctl.hold_w) begin
            r_w     <= w_idx;
            r_other <= r_rpartner[w_idx];
        end
        if (i_ctl.cap_rank) begin
            r_rank_m <= r_rank_rd;
        end
        if (i_ctl.match_free) begin
            r_rpartner[w_idx] <= r_m;
            r_ppartner[r_m]   <= w_idx;
        end
        if (i_ctl.swap) begin
            r_rpartner[r_w] <= r_m;
            r_ppartner[r_m] <= r_w;
            r_queue[r_tail] <= r_other;
        end
        if (i_ctl.emit) begin
            r_proposer <= FIELD_W'(r_oidx);
            r_partner  <= r_pmatch[r_oidx] ? FIELD_W'(r_ppartner[r_oidx]) : '0;
            r_last     <= o_sts.out_last;
        end
    end

    // queue pointers, result index, output flag, active_count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_oidx      <= '0;
            r_out_valid <= 1'b0;
            r_ac        <= AC_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_ac <= i_cfg_data;
            end
            if (i_ctl.init) begin
                r_head  <= '0;
                r_tail  <= (int'(people) == MAX_PEOPLE) ? '0 : IW'(people);
                r_count <= people;
                r_oidx  <= '0;
            end
            if (i_ctl.pop) begin
                r_head  <= (r_head == IW'(MAX_PEOPLE - 1)) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end
            if (i_ctl.swap) begin
                r_tail  <= (r_tail == IW'(MAX_PEOPLE - 1)) ? '0 : r_tail + 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (i_ctl.emit) begin
                r_oidx      <= r_oidx + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.queue_empty = (r_count == '0);
        o_sts.exhausted   = (r_nc[r_m] >= people);
        o_sts.w_in_range  = (int'(r_pref_rd) < int'(people));
        o_sts.w_free      = !r_rmatch[w_idx];
        o_sts.rank_better = (r_rank_m < r_rank_rd);
        o_sts.out_free    = !r_out_valid || i_out_ready;
        o_sts.out_last    = (int'(r_oidx) == int'(people) - 1);
    end

    assign o_out_valid = r_out_valid;
    assign o_proposer  = r_proposer;
    assign o_partner   = r_partner;
    assign o_last      = r_last;

endmodule

// File: rtl/stable_matching_engine_unit.sv
// stable matching engine: proposer-optimal matching by the deferred
// acceptance scheme
// i_req: one transaction per command; proposer load writes choice at rank
//   of proposer person, reviewer load writes rank of proposer choice for
//   reviewer person, run computes the matching; loads give no result
// o_res: a run gives one transaction per proposer in index order, partner
//   0 for an unmatched proposer, last set on proposer n-1
// i_cfg: writes active_count (n), always ready; the user must write it only
//   while idle; the block does not enforce this
// sequencing: a load is written as it is taken and the next command is
//   taken in the cycle after; a run passes INIT to set up, POP per queue
//   pop, CHECK and PREF per proposal a free or out-of-range reviewer
//   settles, CHECK, PREF, RANK1 and RANK2 per proposal needing a rank
//   compare (two reads on the rank-of table port), a pop per displaced
//   proposer, a CHECK per proposer whose list runs out, a POP finding the
//   queue empty, then OUT for the results; the proposal sequencer is serial
// i_req is not ready during a run; the last result may still wait in the
//   output register while the next command is taken
// reset: state machine idle, output empty, active_count 16; tables keep
//   their contents and need loading before a run
// a stall on o_res holds the result and pauses the result sweep
module stable_matching_engine_unit #(
    parameter int MAX_PEOPLE = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sme_in_if.sink          i_req,
    sme_out_if.source       o_res,
    sme_cfg_if.sink         i_cfg
);
    import sme_pkg::*;

    t_ctrl   ctl;
    t_status sts;

    sme_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req.valid),
        .i_req_command (i_req.command),
        .i_sts         (sts),
        .o_ctl         (ctl)
    );

    sme_datapath #(
        .MAX_PEOPLE (MAX_PEOPLE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_person    (i_req.person),
        .i_rank      (i_req.rank),
        .i_choice    (i_req.choice),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_proposer  (o_res.proposer),
        .o_partner   (o_res.partner),
        .o_last      (o_res.last)
    );

    assign i_req.ready = ctl.take;
    assign i_cfg.ready = 1'b1;

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.emit |-> sts.out_free)
        else $error("result written over a waiting transaction");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.pop |-> !sts.queue_empty)
        else $error("pop from empty free queue");

    a_pref_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.issue_pref |-> !sts.exhausted)
        else $error("proposal past end of list");

    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.swap |-> $past(ctl.cap_rank))
        else $error("swap without both rank reads");
`endif

endmodule
